// ===== src/rwqs_pkg.sv =====
// shared types and constants of the ready/wait queue scheduler
package rwqs_pkg;

  localparam int DefQueueDepth = 16;
  localparam int DefTimeBits   = 10;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_PRIO = 2'd1,
    POL_SRT  = 2'd2,
    POL_RSVD = 2'd3
  } policy_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WAKE_RD,
    ST_WAKE_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_CMP_RD,
    ST_CMP_WR,
    ST_FINISH,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic take;
    logic load;
    logic start;
    logic wake_wr;
    logic scan_rd;
    logic scan_cmp;
    logic cmp_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_round;
    logic wake_ok;
    logic ready_zero;
    logic scan_more;
    logic cmp_more;
  } sts_t;

endpackage

// ===== src/rwqs_ram.sv =====
// generic single write port ram with registered read
module rwqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/rwqs_ctrl.sv =====
// scheduler control state machine
module rwqs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rwqs_pkg::sts_t sts_i,
  output rwqs_pkg::cmd_t cmd_o
);
  import rwqs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts_i.is_round) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RESP;
        end else begin
          cmd_o.start = 1'b1;
          if (sts_i.wake_ok) begin
            state_d = ST_WAKE_RD;
          end else if (sts_i.ready_zero) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_WAKE_RD: state_d = ST_WAKE_WR;
      ST_WAKE_WR: begin
        cmd_o.wake_wr = 1'b1;
        state_d       = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = sts_i.scan_more ? ST_SCAN_RD : ST_CMP_RD;
      end
      ST_CMP_RD: begin
        state_d = sts_i.cmp_more ? ST_CMP_WR : ST_FINISH;
      end
      ST_CMP_WR: begin
        cmd_o.cmp_wr = 1'b1;
        state_d      = ST_CMP_RD;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/rwqs_dp.sv =====
// scheduler datapath: queues, counters, selection and result registers
module rwqs_dp #(
  parameter int QUEUE_DEPTH = rwqs_pkg::DefQueueDepth,
  parameter int TIME_BITS   = rwqs_pkg::DefTimeBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rwqs_pkg::cmd_t cmd_i,
  output rwqs_pkg::sts_t sts_o,
  input  logic [1:0]     policy_i,
  input  logic           opcode_i,
  input  logic [3:0]     proc_id_i,
  input  logic [3:0]     proc_priority_i,
  input  logic [9:0]     proc_time_i,
  input  logic           start_waiting_i,
  input  logic           wake_one_i,
  input  logic [7:0]     time_slice_i,
  input  logic           send_to_wait_i,
  output logic           accepted_o,
  output logic           dispatched_o,
  output logic [15:0]    round_number_o,
  output logic [3:0]     run_id_o,
  output logic [7:0]     run_slice_o,
  output logic           completed_o,
  output logic [9:0]     time_left_o,
  output logic [9:0]     total_time_o,
  output logic [3:0]     run_priority_o,
  output logic           ready_empty_o,
  output logic           wait_empty_o
);
  import rwqs_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = CW + 1;
  localparam int TB = TIME_BITS;
  localparam int EW = 8 + 2 * TB;
  localparam int MW = (TB > 8) ? TB : 8;

  logic [CW-1:0] rcnt_q, rcnt_d, wcnt_q, wcnt_d;
  logic [IW-1:0] head_q, head_d;
  logic [15:0]   round_q, round_d;
  logic          op_q, stw_q, wake_q, sendw_q;
  logic [3:0]    id_q, prio_q;
  logic [TB-1:0] time_q;
  logic [7:0]    slice_q;
  logic [IW-1:0] idx_q, idx_d, best_q, best_d, cidx_q, cidx_d;
  logic [EW-1:0] best_e_q, best_e_d;

  logic          res_acc_q, res_acc_d, res_disp_q, res_disp_d, res_done_q, res_done_d;
  logic [3:0]    res_id_q, res_id_d, res_prio_q, res_prio_d;
  logic [7:0]    res_slice_q, res_slice_d;
  logic [TB-1:0] res_rem_q, res_rem_d, res_tot_q, res_tot_d;

  logic          r_we, w_we;
  logic [IW-1:0] r_waddr, r_raddr, w_waddr;
  logic [EW-1:0] r_wdata, w_wdata, r_rdata, w_rdata;

  logic          ready_full, wait_full, take_new, pol_prio, pol_srt, done;
  logic          req_wait, req_ready;
  logic [TW-1:0] tail_sum;
  logic [IW-1:0] tail;
  logic [EW-1:0] new_e, requeue_e;
  logic [TB-1:0] best_rem, new_rem;

  rwqs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  rwqs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(head_q),
    .rdata_o(w_rdata)
  );

  assign ready_full = rcnt_q == CW'(QUEUE_DEPTH);
  assign wait_full  = wcnt_q == CW'(QUEUE_DEPTH);
  assign tail_sum   = TW'(head_q) + TW'(wcnt_q);
  assign tail       = (tail_sum >= TW'(QUEUE_DEPTH)) ? IW'(tail_sum - TW'(QUEUE_DEPTH))
                                                    : IW'(tail_sum);
  assign pol_prio   = policy_i == POL_PRIO;
  assign pol_srt    = policy_i == POL_SRT;
  assign new_e      = {id_q, prio_q, time_q, time_q};

  assign take_new = (idx_q == '0)
                 || (pol_prio && (r_rdata[EW-5 -: 4] > best_e_q[EW-5 -: 4]))
                 || (pol_srt && (r_rdata[2*TB-1 -: TB] < best_e_q[2*TB-1 -: TB]));

  assign best_rem  = best_e_q[2*TB-1 -: TB];
  assign done      = MW'(best_rem) <= MW'(slice_q);
  assign new_rem   = best_rem - TB'(slice_q);
  assign requeue_e = {best_e_q[EW-1 -: 8], new_rem, best_e_q[TB-1:0]};
  assign req_wait  = !done && sendw_q && !wait_full;
  assign req_ready = !done && !req_wait;

  assign sts_o.is_round   = op_q;
  assign sts_o.wake_ok    = wake_q && (wcnt_q != '0) && !ready_full;
  assign sts_o.ready_zero = rcnt_q == '0;
  assign sts_o.scan_more  = (pol_prio || pol_srt) && ((CW'(idx_q) + CW'(1)) < rcnt_q);
  assign sts_o.cmp_more   = (CW'(cidx_q) + CW'(1)) < rcnt_q;

  assign r_raddr = cmd_i.scan_rd ? idx_q : IW'(CW'(cidx_q) + CW'(1));

  always_comb begin
    r_we    = 1'b0;
    r_waddr = IW'(rcnt_q);
    r_wdata = new_e;
    w_we    = 1'b0;
    w_waddr = tail;
    w_wdata = new_e;
    rcnt_d  = rcnt_q;
    wcnt_d  = wcnt_q;
    head_d  = head_q;
    round_d = round_q;
    idx_d   = idx_q;
    best_d  = best_q;
    cidx_d  = cidx_q;
    best_e_d    = best_e_q;
    res_acc_d   = res_acc_q;
    res_disp_d  = res_disp_q;
    res_done_d  = res_done_q;
    res_id_d    = res_id_q;
    res_prio_d  = res_prio_q;
    res_slice_d = res_slice_q;
    res_rem_d   = res_rem_q;
    res_tot_d   = res_tot_q;

    if (cmd_i.load) begin
      res_acc_d   = 1'b0;
      res_disp_d  = 1'b0;
      res_done_d  = 1'b0;
      res_id_d    = '0;
      res_prio_d  = '0;
      res_slice_d = '0;
      res_rem_d   = '0;
      res_tot_d   = '0;
      if (stw_q) begin
        if (!wait_full) begin
          w_we      = 1'b1;
          wcnt_d    = wcnt_q + CW'(1);
          res_acc_d = 1'b1;
        end
      end else if (!ready_full) begin
        r_we      = 1'b1;
        rcnt_d    = rcnt_q + CW'(1);
        res_acc_d = 1'b1;
      end
    end

    if (cmd_i.start) begin
      round_d     = round_q + 16'd1;
      idx_d       = '0;
      best_d      = '0;
      res_acc_d   = 1'b0;
      res_disp_d  = 1'b0;
      res_done_d  = 1'b0;
      res_id_d    = '0;
      res_prio_d  = '0;
      res_slice_d = '0;
      res_rem_d   = '0;
      res_tot_d   = '0;
    end

    if (cmd_i.wake_wr) begin
      r_we    = 1'b1;
      r_wdata = w_rdata;
      rcnt_d  = rcnt_q + CW'(1);
      wcnt_d  = wcnt_q - CW'(1);
      head_d  = (CW'(head_q) + CW'(1) == CW'(QUEUE_DEPTH)) ? '0 : head_q + IW'(1);
    end

    if (cmd_i.scan_cmp) begin
      if (take_new) begin
        best_d   = idx_q;
        best_e_d = r_rdata;
      end
      idx_d  = idx_q + IW'(1);
      cidx_d = take_new ? idx_q : best_q;
    end

    if (cmd_i.cmp_wr) begin
      r_we    = 1'b1;
      r_waddr = cidx_q;
      r_wdata = r_rdata;
      cidx_d  = cidx_q + IW'(1);
    end

    if (cmd_i.finish) begin
      res_disp_d  = 1'b1;
      res_id_d    = best_e_q[EW-1 -: 4];
      res_prio_d  = best_e_q[EW-5 -: 4];
      res_tot_d   = best_e_q[TB-1:0];
      res_slice_d = slice_q;
      res_done_d  = done;
      res_rem_d   = done ? '0 : new_rem;
      if (req_ready) begin
        r_we    = 1'b1;
        r_waddr = IW'(rcnt_q - CW'(1));
        r_wdata = requeue_e;
      end else begin
        rcnt_d = rcnt_q - CW'(1);
      end
      if (req_wait) begin
        w_we    = 1'b1;
        w_wdata = requeue_e;
        wcnt_d  = wcnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q  <= '0;
      wcnt_q  <= '0;
      head_q  <= '0;
      round_q <= '0;
      op_q    <= 1'b0;
      wake_q  <= 1'b0;
      idx_q   <= '0;
      best_q  <= '0;
      cidx_q  <= '0;
    end else begin
      rcnt_q  <= rcnt_d;
      wcnt_q  <= wcnt_d;
      head_q  <= head_d;
      round_q <= round_d;
      idx_q   <= idx_d;
      best_q  <= best_d;
      cidx_q  <= cidx_d;
      if (cmd_i.take) begin
        op_q   <= opcode_i;
        wake_q <= wake_one_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      id_q    <= proc_id_i;
      prio_q  <= proc_priority_i;
      time_q  <= TB'(proc_time_i);
      stw_q   <= start_waiting_i;
      slice_q <= time_slice_i;
      sendw_q <= send_to_wait_i;
    end
    best_e_q    <= best_e_d;
    res_acc_q   <= res_acc_d;
    res_disp_q  <= res_disp_d;
    res_done_q  <= res_done_d;
    res_id_q    <= res_id_d;
    res_prio_q  <= res_prio_d;
    res_slice_q <= res_slice_d;
    res_rem_q   <= res_rem_d;
    res_tot_q   <= res_tot_d;
  end

  assign accepted_o     = res_acc_q;
  assign dispatched_o   = res_disp_q;
  assign round_number_o = round_q;
  assign run_id_o       = res_id_q;
  assign run_slice_o    = res_slice_q;
  assign completed_o    = res_done_q;
  assign time_left_o    = 10'(res_rem_q);
  assign total_time_o   = 10'(res_tot_q);
  assign run_priority_o = res_prio_q;
  assign ready_empty_o  = rcnt_q == '0;
  assign wait_empty_o   = wcnt_q == '0;

endmodule

// ===== src/ready_wait_queue_scheduler.sv =====
// ready/wait queue process scheduler top level with register port
// One beat at a time. A load passes through decode to the result state, and so does
// a round that finds the ready queue empty. A round that runs an entry adds a wake
// read and write when a wake can be done, a read and a compare per ready entry
// scanned (one entry under first come first served, all entries under priority or
// least remaining time), a read and a write per entry shifted down when the selected
// entry is removed from the compacted ready queue, and a finish step. The scan and
// shift go one entry at a time through the single read port of the ready queue memory.
module ready_wait_queue_scheduler #(
  parameter int QUEUE_DEPTH = rwqs_pkg::DefQueueDepth,
  parameter int TIME_BITS   = rwqs_pkg::DefTimeBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [3:0]  proc_id_i,
  input  logic [3:0]  proc_priority_i,
  input  logic [9:0]  proc_time_i,
  input  logic        start_waiting_i,
  input  logic        wake_one_i,
  input  logic [7:0]  time_slice_i,
  input  logic        send_to_wait_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic        dispatched_o,
  output logic [15:0] round_number_o,
  output logic [3:0]  run_id_o,
  output logic [7:0]  run_slice_o,
  output logic        completed_o,
  output logic [9:0]  time_left_o,
  output logic [9:0]  total_time_o,
  output logic [3:0]  run_priority_o,
  output logic        ready_empty_o,
  output logic        wait_empty_o
);
  import rwqs_pkg::*;

  logic [1:0] policy_q;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, policy_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FCFS;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      policy_q <= pwdata[1:0];
    end
  end

  rwqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwqs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .policy_i       (policy_q),
    .opcode_i       (opcode_i),
    .proc_id_i      (proc_id_i),
    .proc_priority_i(proc_priority_i),
    .proc_time_i    (proc_time_i),
    .start_waiting_i(start_waiting_i),
    .wake_one_i     (wake_one_i),
    .time_slice_i   (time_slice_i),
    .send_to_wait_i (send_to_wait_i),
    .accepted_o     (accepted_o),
    .dispatched_o   (dispatched_o),
    .round_number_o (round_number_o),
    .run_id_o       (run_id_o),
    .run_slice_o    (run_slice_o),
    .completed_o    (completed_o),
    .time_left_o    (time_left_o),
    .total_time_o   (total_time_o),
    .run_priority_o (run_priority_o),
    .ready_empty_o  (ready_empty_o),
    .wait_empty_o   (wait_empty_o)
  );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the ready/wait queue scheduler
module testbench;
  import rwqs_pkg::*;

  localparam int Depth      = 16;
  localparam int CycleLimit = 2000000;
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ROUND = 1'b1;
  localparam logic [2:0] ADDR_POLICY = 3'd0;

  typedef struct packed {
    logic [3:0] id;
    logic [3:0] prio;
    logic [9:0] remaining;
    logic [9:0] total;
  } proc_t;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  id;
    logic [3:0]  prio;
    logic [9:0]  ptime;
    logic        start_waiting;
    logic        wake;
    logic [7:0]  slice;
    logic        to_wait;
  } beat_t;

  localparam int BeatBits = $bits(beat_t);

  typedef struct packed {
    logic        accepted;
    logic        dispatched;
    logic [15:0] round_number;
    logic [3:0]  run_id;
    logic [7:0]  run_slice;
    logic        completed;
    logic [9:0]  time_left;
    logic [9:0]  total_time;
    logic [3:0]  run_priority;
    logic        ready_empty;
    logic        wait_empty;
  } outcome_t;

  typedef struct {
    beat_t    stim;
    logic     has_known;
    outcome_t known;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  beat_t drive = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  outcome_t seen;

  ready_wait_queue_scheduler i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o,
    .opcode_i(drive.opcode), .proc_id_i(drive.id), .proc_priority_i(drive.prio),
    .proc_time_i(drive.ptime), .start_waiting_i(drive.start_waiting),
    .wake_one_i(drive.wake), .time_slice_i(drive.slice), .send_to_wait_i(drive.to_wait),
    .out_valid_o, .out_ready_i,
    .accepted_o(seen.accepted), .dispatched_o(seen.dispatched),
    .round_number_o(seen.round_number), .run_id_o(seen.run_id),
    .run_slice_o(seen.run_slice), .completed_o(seen.completed),
    .time_left_o(seen.time_left), .total_time_o(seen.total_time),
    .run_priority_o(seen.run_priority), .ready_empty_o(seen.ready_empty),
    .wait_empty_o(seen.wait_empty)
  );

  always #5 clk_i = ~clk_i;

  // scheduler state mirror
  proc_t       ready_q[$];
  proc_t       wait_q[$];
  logic [15:0] rounds;
  policy_e     cur_policy;
  outcome_t    pending_results[$];
  int          errors;
  int          cycles;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic outcome_t schedule(input beat_t b);
    outcome_t o;
    proc_t p;
    int best;
    o = '0;
    if (b.opcode == OP_LOAD) begin
      p.id = b.id; p.prio = b.prio; p.remaining = b.ptime; p.total = b.ptime;
      if (b.start_waiting) begin
        if (wait_q.size() < Depth) begin
          wait_q.insert(wait_q.size(), p);
          o.accepted = 1'b1;
        end
      end else if (ready_q.size() < Depth) begin
        ready_q.insert(ready_q.size(), p);
        o.accepted = 1'b1;
      end
    end else begin
      rounds = rounds + 16'd1;
      if (b.wake && wait_q.size() > 0 && ready_q.size() < Depth) begin
        p = wait_q.pop_front();
        ready_q.insert(ready_q.size(), p);
      end
      if (ready_q.size() > 0) begin
        best = 0;
        for (int i = 1; i < ready_q.size(); i++) begin
          if (cur_policy == POL_PRIO && ready_q[i].prio > ready_q[best].prio) best = i;
          if (cur_policy == POL_SRT && ready_q[i].remaining < ready_q[best].remaining)
            best = i;
        end
        p = ready_q[best];
        ready_q.delete(best);
        o.dispatched = 1'b1;
        o.run_id = p.id;
        o.run_slice = b.slice;
        o.total_time = p.total;
        o.run_priority = p.prio;
        if (p.remaining <= {2'b0, b.slice}) begin
          o.completed = 1'b1;
        end else begin
          p.remaining = p.remaining - {2'b0, b.slice};
          o.time_left = p.remaining;
          if (b.to_wait && wait_q.size() < Depth) wait_q.insert(wait_q.size(), p);
          else ready_q.insert(ready_q.size(), p);
        end
      end
    end
    o.round_number = rounds;
    o.ready_empty = ready_q.size() == 0;
    o.wait_empty = wait_q.size() == 0;
    return o;
  endfunction

  function automatic int gap_len();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    return n;
  endfunction

  task automatic send(input beat_t b);
    int n;
    n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drive <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), schedule(b));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_policy(input policy_e pol);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_POLICY; pwdata <= {30'b0, pol};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_policy = pol;
    @(posedge clk_i);
  endtask

  function automatic beat_t load_beat(input logic [3:0] id, input logic [3:0] prio,
                                      input logic [9:0] t, input logic to_wait);
    beat_t b;
    b = '0;
    b.opcode = OP_LOAD; b.id = id; b.prio = prio; b.ptime = t; b.start_waiting = to_wait;
    return b;
  endfunction

  function automatic beat_t round_beat(input logic wake, input logic [7:0] slice,
                                       input logic to_wait);
    beat_t b;
    b = BeatBits'($urandom());
    b.opcode = OP_ROUND; b.wake = wake; b.slice = slice; b.to_wait = to_wait;
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b = BeatBits'($urandom());
    b.ptime = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(1, 300));
    b.opcode = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_ROUND;
    return b;
  endfunction

  // output side: random stall and check against the oldest expectation
  always @(posedge clk_i) begin
    outcome_t want;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (seen.accepted !== want.accepted) report("accepted");
          if (seen.dispatched !== want.dispatched) report("dispatched");
          if (seen.round_number !== want.round_number) report("round_number");
          if (seen.run_id !== want.run_id) report("run_id");
          if (seen.run_slice !== want.run_slice) report("run_slice");
          if (seen.completed !== want.completed) report("completed");
          if (seen.time_left !== want.time_left) report("time_left");
          if (seen.total_time !== want.total_time) report("total_time");
          if (seen.run_priority !== want.run_priority) report("run_priority");
          if (seen.ready_empty !== want.ready_empty) report("ready_empty");
          if (seen.wait_empty !== want.wait_empty) report("wait_empty");
        end
      end
      out_ready_i <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                     ($urandom_range(0, 99) < 70) ? 1'b1 : 1'($urandom_range(0, 1));
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  row_t rows[$];
  int sent;

  initial begin
    row_t r;
    outcome_t k;
    errors = 0;
    cycles = 0;
    rounds = '0;
    cur_policy = POL_FCFS;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: empty round
    k = '0; k.round_number = 16'd1; k.ready_empty = 1'b1; k.wait_empty = 1'b1;
    r.stim = round_beat(1'b1, 8'd255, 1'b1); r.has_known = 1'b1; r.known = k;
    rows.insert(rows.size(), r);
    k = '0; k.accepted = 1'b1; k.round_number = 16'd1; k.wait_empty = 1'b1;
    r.stim = load_beat(4'hf, 4'hf, 10'd1023, 1'b0); r.known = k; rows.insert(rows.size(), r);
    k = '0; k.dispatched = 1'b1; k.round_number = 16'd2; k.run_id = 4'hf;
    k.run_slice = 8'd255; k.time_left = 10'd768; k.total_time = 10'd1023;
    k.run_priority = 4'hf; k.ready_empty = 1'b1;
    r.stim = round_beat(1'b0, 8'd255, 1'b1); r.known = k; rows.insert(rows.size(), r);
    r.has_known = 1'b0;
    r.stim = load_beat(4'h0, 4'h0, 10'd0, 1'b0); rows.insert(rows.size(), r);
    r.stim = round_beat(1'b0, 8'd0, 1'b0); rows.insert(rows.size(), r);
    r.stim = round_beat(1'b1, 8'd1, 1'b0); rows.insert(rows.size(), r);
    for (int i = 0; i < 17; i++) begin
      r.stim = load_beat(i[3:0], ~i[3:0], 10'(i + 1), 1'b1); rows.insert(rows.size(), r);
    end
    r.stim = round_beat(1'b1, 8'd0, 1'b1); rows.insert(rows.size(), r);

    foreach (rows[i]) begin
      send(rows[i].stim);
      if (rows[i].has_known) pending_results[pending_results.size() - 1] = rows[i].known;
    end
    drain();

    // each policy, extremes included; random fill and rounds
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_policy(policy_e'(ph % 4));
      for (int i = 0; i < 150; i++) begin
        send(random_beat());
        sent++;
      end
      drain();
    end
    write_policy(POL_SRT);
    while (sent < 1225) begin
      send(random_beat());
      sent++;
    end
    drain();

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
